// ===== rtl/fbfla_pkg.sv =====
// Shared types and constants of the fixed block free list allocator.
// Used by fbfla_ctrl, fbfla_datapath and the top level; depends on nothing.
package fbfla_pkg;

  localparam int ACTION_W   = 1;
  localparam int CHUNK_W    = 3;
  localparam int BLOCK_W    = 8;
  localparam int STATUS_W   = 3;
  localparam int OFFSET_W   = 24;
  localparam int LEFT_W     = 8;
  localparam int BYTES_W    = 16;

  localparam int IN_DATA_W  = 16;
  localparam int IN_USER_W  = ACTION_W;
  localparam int OUT_DATA_W = 48;
  localparam int OUT_USER_W = STATUS_W;
  localparam int OUT_PAD_W  = OUT_DATA_W - (CHUNK_W + BLOCK_W + OFFSET_W + LEFT_W);

  localparam logic [ACTION_W-1:0] ACT_ALLOC = 1'b0;
  localparam logic [ACTION_W-1:0] ACT_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NO_CHUNK  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_BLOCK = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

  localparam logic [BYTES_W-1:0] BLOCK_BYTES_RESET = 16'd8;

  typedef struct packed {
    logic load_item;
    logic decide;
    logic init_step;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_create;
    logic init_last;
    logic out_free;
  } dp_status_t;

endpackage

// ===== rtl/fbfla_ctrl.sv =====
// Controller state machine of the allocator: sequences accept, decide,
// chunk link initialization and result hand-off. Depends on fbfla_pkg.
module fbfla_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  fbfla_pkg::dp_status_t status,
  output fbfla_pkg::ctrl_cmd_t  cmd
);
  import fbfla_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DECIDE = 2'd1;
  localparam logic [1:0] S_INIT   = 2'd2;
  localparam logic [1:0] S_FIN    = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        state_next = status.need_create ? S_INIT : S_FIN;
      end
      S_INIT: begin
        if (status.init_last) state_next = S_DECIDE;
      end
      S_FIN: begin
        if (status.out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready       = (state == S_IDLE);
  assign cmd.load_item  = (state == S_IDLE) && s_tvalid;
  assign cmd.decide     = (state == S_DECIDE);
  assign cmd.init_step  = (state == S_INIT);
  assign cmd.finish     = (state == S_FIN) && status.out_free;

endmodule

// ===== rtl/fbfla_datapath.sv =====
// Datapath of the allocator: link memory, per-chunk heads and counts,
// chunk selection, offset multiplier and the result register. Depends on fbfla_pkg.
module fbfla_datapath #(
  parameter int MAX_CHUNKS       = 8,
  parameter int BLOCKS_PER_CHUNK = 255
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  fbfla_pkg::ctrl_cmd_t                 cmd,
  output fbfla_pkg::dp_status_t                status,
  input  logic [fbfla_pkg::IN_DATA_W-1:0]      s_tdata,
  input  logic [fbfla_pkg::IN_USER_W-1:0]      s_tuser,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [fbfla_pkg::OUT_DATA_W-1:0]     m_tdata,
  output logic [fbfla_pkg::OUT_USER_W-1:0]     m_tuser,
  input  logic                                 cfg_valid,
  input  logic [fbfla_pkg::BYTES_W-1:0]        cfg_data
);
  import fbfla_pkg::*;

  localparam int CI_W   = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int CNT_W  = $clog2(MAX_CHUNKS + 1);
  localparam int CMP_W  = (CNT_W > CHUNK_W) ? CNT_W : CHUNK_W;
  localparam int ADDR_W = CI_W + BLOCK_W;
  localparam int DEPTH  = MAX_CHUNKS << BLOCK_W;
  localparam logic [BLOCK_W-1:0] BPC      = BLOCK_W'(BLOCKS_PER_CHUNK);
  localparam logic [BLOCK_W-1:0] BPC_LAST = BLOCK_W'(BLOCKS_PER_CHUNK - 1);
  localparam logic [CNT_W-1:0]   MAXC     = CNT_W'(MAX_CHUNKS);

  logic [BLOCK_W-1:0]  links [DEPTH];
  logic [BLOCK_W-1:0]  link_rd;
  logic [BLOCK_W-1:0]  head [MAX_CHUNKS];
  logic [LEFT_W-1:0]   count [MAX_CHUNKS];
  logic [CNT_W-1:0]    created;
  logic [CI_W-1:0]     last_chunk;
  logic                last_valid;
  logic [BYTES_W-1:0]  block_bytes;

  logic [ACTION_W-1:0] item_act;
  logic [CHUNK_W-1:0]  item_chunk;
  logic [BLOCK_W-1:0]  item_block;
  logic [BLOCK_W-1:0]  init_idx;

  logic                take_pend;
  logic [CI_W-1:0]     take_chunk;
  logic [BLOCK_W-1:0]  take_head;

  logic [STATUS_W-1:0] r_status;
  logic [CHUNK_W-1:0]  r_chunk;
  logic [BLOCK_W-1:0]  r_block;
  logic [LEFT_W-1:0]   r_left;
  logic                r_use_off;
  logic [OFFSET_W-1:0] product;

  logic [MAX_CHUNKS-1:0] nz;
  logic                hit_last;
  logic                scan_found;
  logic [CI_W-1:0]     scan_chunk;
  logic                is_alloc;
  logic                take;
  logic                need_create;
  logic [CI_W-1:0]     sel;
  logic [BLOCK_W-1:0]  sel_head;
  logic [LEFT_W-1:0]   sel_count;
  logic                no_chunk;
  logic                bad_block;
  logic                chunk_full;
  logic                free_ok;
  logic [BLOCK_W-1:0]  mul_blk;
  logic [CI_W-1:0]     new_chunk;

  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;
  logic [BLOCK_W-1:0]  mem_wdata;
  logic                mem_re;
  logic [ADDR_W-1:0]   mem_raddr;

  always_comb begin
    for (int k = 0; k < MAX_CHUNKS; k++) begin
      nz[k] = (count[k] != '0);
    end
  end

  always_comb begin
    scan_found = 1'b0;
    scan_chunk = '0;
    for (int k = 0; k < MAX_CHUNKS; k++) begin
      if (nz[k] && (CNT_W'(k) < created)) begin
        scan_found = 1'b1;
        scan_chunk = CI_W'(k);
      end
    end
  end

  assign is_alloc    = (item_act == ACT_ALLOC);
  assign hit_last    = last_valid && (CNT_W'(last_chunk) < created) && nz[last_chunk];
  assign take        = hit_last || scan_found;
  assign need_create = is_alloc && !take && (created < MAXC);
  assign new_chunk   = created[CI_W-1:0];

  assign sel       = is_alloc ? (hit_last ? last_chunk : scan_chunk) : CI_W'(item_chunk);
  assign sel_head  = head[sel];
  assign sel_count = count[sel];

  assign no_chunk   = (CMP_W'(item_chunk) >= CMP_W'(created));
  assign bad_block  = (item_block >= BPC);
  assign chunk_full = (sel_count >= BPC);
  assign free_ok    = !is_alloc && !no_chunk && !bad_block && !chunk_full;
  assign mul_blk    = is_alloc ? sel_head : item_block;

  assign status.need_create = need_create;
  assign status.init_last   = (init_idx == BPC_LAST);
  assign status.out_free    = !m_tvalid || m_tready;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {sel, item_block};
    mem_wdata = sel_head;
    if (cmd.init_step) begin
      mem_we    = 1'b1;
      mem_waddr = {new_chunk, init_idx};
      mem_wdata = init_idx + 1'b1;
    end else if (cmd.decide && free_ok) begin
      mem_we = 1'b1;
    end
  end

  assign mem_re    = cmd.decide && is_alloc && take && (sel_head < BPC);
  assign mem_raddr = {sel, sel_head};

  always_ff @(posedge clk) begin
    if (mem_we) links[mem_waddr] <= mem_wdata;
    if (mem_re) link_rd <= links[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_bytes <= BLOCK_BYTES_RESET;
    end else if (cfg_valid) begin
      block_bytes <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_act   <= s_tuser[ACTION_W-1:0];
      item_chunk <= s_tdata[CHUNK_W-1:0];
      item_block <= s_tdata[CHUNK_W +: BLOCK_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      created    <= '0;
      last_chunk <= '0;
      last_valid <= 1'b0;
      take_pend  <= 1'b0;
      init_idx   <= '0;
    end else begin
      if (cmd.decide) begin
        init_idx  <= '0;
        take_pend <= 1'b0;
        if (!need_create) begin
          product   <= OFFSET_W'(mul_blk) * OFFSET_W'(block_bytes);
          r_use_off <= 1'b0;
          r_chunk   <= item_chunk;
          r_block   <= item_block;
          r_left    <= '0;
          if (is_alloc) begin
            if (take) begin
              r_status   <= ST_OK;
              r_use_off  <= 1'b1;
              r_chunk    <= CHUNK_W'(sel);
              r_block    <= sel_head;
              r_left     <= sel_count - 1'b1;
              count[sel] <= sel_count - 1'b1;
              last_chunk <= sel;
              last_valid <= 1'b1;
              take_pend  <= 1'b1;
              take_chunk <= sel;
              take_head  <= sel_head;
            end else begin
              r_status <= ST_EXHAUSTED;
              r_chunk  <= '0;
              r_block  <= '0;
            end
          end else if (no_chunk) begin
            r_status <= ST_NO_CHUNK;
          end else if (bad_block) begin
            r_status <= ST_BAD_BLOCK;
            r_left   <= sel_count;
          end else if (chunk_full) begin
            r_status <= ST_FULL;
            r_left   <= sel_count;
          end else begin
            r_status   <= ST_OK;
            r_use_off  <= 1'b1;
            r_left     <= sel_count + 1'b1;
            head[sel]  <= item_block;
            count[sel] <= sel_count + 1'b1;
          end
        end
      end
      if (cmd.init_step) begin
        init_idx <= init_idx + 1'b1;
        if (status.init_last) begin
          head[new_chunk]  <= '0;
          count[new_chunk] <= BPC;
          created          <= created + 1'b1;
        end
      end
      if (cmd.finish && take_pend) begin
        head[take_chunk] <= (take_head < BPC) ? link_rd : take_head;
        take_pend        <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      m_tuser <= r_status;
      m_tdata <= {{OUT_PAD_W{1'b0}}, r_left, (r_use_off ? product : OFFSET_W'(0)),
                  r_block, r_chunk};
    end
  end

endmodule

// ===== rtl/fixed_block_free_list_allocator_core.sv =====
// Top level of the fixed block free list allocator core.
// Instantiates fbfla_ctrl and fbfla_datapath; depends on fbfla_pkg.
//
//   Channel  Dir  Handshake              Contents
//   s_*      in   s_tvalid / s_tready    tuser action; tdata chunk_index, block_index
//   m_*      out  m_tvalid / m_tready    tuser status; tdata chunk, block, offset, left
//   cfg_*    in   cfg_valid / cfg_ready  block_bytes register
//
// A beat passes through accept, then decide with one link memory access and the offset
// multiply, then the head update and hand-off that load the result register.
// An allocate that opens a new chunk first runs chunk link initialization: the single link
// memory write port writes that chunk's links one entry per cycle, then decide runs again.
// Reset clears chunk bookkeeping and the output valid; no memory clearing pass is run.
// A stalled result holds the block in its finish state until m_tready frees the slot.
module fixed_block_free_list_allocator_core #(
  parameter int MAX_CHUNKS       = 8,
  parameter int BLOCKS_PER_CHUNK = 255
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // [2:0] chunk_index, [10:3] block_index, [15:11] zero
  input  logic [fbfla_pkg::IN_DATA_W-1:0]  s_tdata,
  // [0] action
  input  logic [fbfla_pkg::IN_USER_W-1:0]  s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // [2:0] result_chunk, [10:3] result_block, [34:11] byte_offset,
  // [42:35] free_left, [47:43] zero
  output logic [fbfla_pkg::OUT_DATA_W-1:0] m_tdata,
  // [2:0] status
  output logic [fbfla_pkg::OUT_USER_W-1:0] m_tuser,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fbfla_pkg::BYTES_W-1:0]    cfg_data
);
  import fbfla_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  fbfla_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  fbfla_datapath #(
    .MAX_CHUNKS       (MAX_CHUNKS),
    .BLOCKS_PER_CHUNK (BLOCKS_PER_CHUNK)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data)
  );

endmodule
